FILE: design/tts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg - shared definitions for the two-tone sine synthesizer
// Table geometry, fixed-point constants, register indexes and the sine lookup.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int TONE_COUNT         = 2;

  localparam int PHASE_BITS      = 32;
  localparam int IDX_BITS        = $clog2(SINE_TABLE_ENTRIES);
  localparam int QUARTER_ENTRIES = SINE_TABLE_ENTRIES / 4;
  localparam int QTR_BITS        = $clog2(QUARTER_ENTRIES);

  localparam int MID_CODE  = 128;
  localparam int MAX_CODE  = 255;
  localparam int FRAC_BITS = 23;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] STEP_Q30    = Q30_ONE / QUARTER_ENTRIES;

  // Taylor series denominators (2n)(2n+1) for n = 1..7.
  localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};

  typedef enum logic [1:0] {
    REG_TONE_A_AMP  = 2'd0,
    REG_TONE_B_AMP  = 2'd1,
    REG_TONE_A_STEP = 2'd2,
    REG_TONE_B_STEP = 2'd3
  } cfg_reg_t;

  typedef logic [15:0] quarter_rom_t [QUARTER_ENTRIES];

  // Magnitude of the sine at quarter-wave position m (0 .. QUARTER_ENTRIES),
  // in Q1.15, evaluated at elaboration to fill the constant table.
  function automatic logic [15:0] sine_mag(input int unsigned m);
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic [63:0]        s;
    logic signed [63:0] acc;
    r   = 64'(m) * STEP_Q30;
    x   = (r * HALF_PI_Q30) >> 30;
    x2  = (x * x) >> 30;
    t   = x;
    acc = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      t = ((t * x2) >> 30) / TAYLOR_DIV[n];
      if ((n % 2) == 1) begin
        acc = acc - $signed(t);
      end else begin
        acc = acc + $signed(t);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    s = $unsigned(acc);
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    s = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return s[15:0];
  endfunction

  function automatic quarter_rom_t build_quarter();
    quarter_rom_t rom;
    for (int m = 0; m < QUARTER_ENTRIES; m++) begin
      rom[m] = sine_mag(m);
    end
    return rom;
  endfunction

  localparam quarter_rom_t SINE_QUARTER = build_quarter();
  localparam logic [15:0]  SINE_PEAK    = sine_mag(QUARTER_ENTRIES);

  // Full-wave sine of a phase, folded onto the quarter-wave table.
  function automatic logic signed [15:0] tone_sine(input logic [PHASE_BITS-1:0] phase);
    logic [IDX_BITS-1:0] idx;
    logic [1:0]          quad;
    logic [QTR_BITS-1:0] low;
    logic [QTR_BITS-1:0] mirror;
    logic [15:0]         mag;
    idx    = phase[PHASE_BITS-1 -: IDX_BITS];
    quad   = idx[IDX_BITS-1 -: 2];
    low    = idx[QTR_BITS-1:0];
    mirror = ~low + QTR_BITS'(1);
    if (!quad[0]) begin
      mag = SINE_QUARTER[low];
    end else if (low == '0) begin
      mag = SINE_PEAK;
    end else begin
      mag = SINE_QUARTER[mirror];
    end
    if (quad[1]) begin
      return -$signed(mag);
    end
    return $signed(mag);
  endfunction

endpackage

FILE: design/two_tone_sine_synthesizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_tone_sine_synthesizer - two-tone DDS with a saturating 8-bit DAC code
// Phase accumulators, quarter-wave sine lookup, scaling, sum and clipping.
// ----------------------------------------------------------------------------
// Usage:
// Every word accepted on the in_ stream is one sample tick. Bit 0 of in_tdata
// is the restart flag, which clears both phase accumulators and the sample
// count before that sample is formed. Each tick yields exactly one word on the
// out_ stream carrying the DAC code, the running sample count and a clip flag.
// The cfg_ port writes the amplitude and phase step registers; the user must
// make writes only while no samples are in flight (the block does not enforce it).
// An accepted input word is registered in the first stage and then in the
// output register, which drives out_tvalid. The block sustains one word per
// clock while out_tready stays high: the first register stage does the phase
// update and the sine table lookup, the second does the two amplitude
// multiplies, the sum and the saturation into the output register.
// When the receiver holds out_tready low the output word stays put, the first
// stage may still fill, and in_tready drops only once both stages are full.
// A synchronous low on rst_n empties the pipeline, zeroes the phases and the
// count, and loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module two_tone_sine_synthesizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] restart, [7:1] zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [7:0] dac_code, [39:8] samples_made
  output logic        out_tuser,   // [0] clipped
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int PB       = tts_pkg::PHASE_BITS;
  localparam int SUM_BITS = 35;
  localparam logic signed [SUM_BITS-1:0] MID_OFFSET =
    SUM_BITS'(tts_pkg::MID_CODE) << tts_pkg::FRAC_BITS;

  // Configuration registers.
  logic [15:0]   amp_a_r;
  logic [15:0]   amp_b_r;
  logic [PB-1:0] step_a_r;
  logic [PB-1:0] step_b_r;

  // Running state: only these feed back from one sample to the next.
  logic [PB-1:0] phase_a_r;
  logic [PB-1:0] phase_b_r;
  logic [31:0]   count_r;

  logic [PB-1:0] phase_a_cur;
  logic [PB-1:0] phase_b_cur;
  logic [PB-1:0] phase_a_nxt;
  logic [PB-1:0] phase_b_nxt;
  logic [31:0]   count_nxt;

  // First stage: looked-up sine values of the current phases.
  logic               s1_valid_r;
  logic signed [15:0] s1_sine_a_r;
  logic signed [15:0] s1_sine_b_r;
  logic [31:0]        s1_count_r;

  // Output register.
  logic        out_valid_r;
  logic [7:0]  out_code_r;
  logic        out_clip_r;
  logic [31:0] out_count_r;

  logic in_fire;
  logic s2_ready;
  logic restart;

  logic signed [32:0]         prod_a;
  logic signed [32:0]         prod_b;
  logic signed [SUM_BITS-1:0] total;
  logic [7:0]                 code;
  logic                       clip;

  // The output register can take a word when empty or being emptied, and
  // the first stage can take one when empty or moving into the output.
  assign s2_ready  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign restart   = in_tdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_a_r  <= 16'd10240;
      amp_b_r  <= 16'd20480;
      step_a_r <= 32'd1288490;
      step_b_r <= 32'd2147484;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        tts_pkg::REG_TONE_A_AMP:  amp_a_r  <= cfg_wdata[15:0];
        tts_pkg::REG_TONE_B_AMP:  amp_b_r  <= cfg_wdata[15:0];
        tts_pkg::REG_TONE_A_STEP: step_a_r <= cfg_wdata;
        tts_pkg::REG_TONE_B_STEP: step_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A restart zeroes the phases and the count before this sample uses them.
  always_comb begin
    phase_a_cur = restart ? '0 : phase_a_r;
    phase_b_cur = restart ? '0 : phase_b_r;
    phase_a_nxt = phase_a_cur + step_a_r;
    // With a single tone the second accumulator does not advance.
    phase_b_nxt = (tts_pkg::TONE_COUNT > 1) ? (phase_b_cur + step_b_r) : phase_b_cur;
    count_nxt   = (restart ? 32'd0 : count_r) + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_a_r <= '0;
      phase_b_r <= '0;
      count_r   <= '0;
    end else if (in_fire) begin
      phase_a_r <= phase_a_nxt;
      phase_b_r <= phase_b_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sine_a_r <= tts_pkg::tone_sine(phase_a_cur);
      s1_sine_b_r <= (tts_pkg::TONE_COUNT > 1) ? tts_pkg::tone_sine(phase_b_cur) : 16'sd0;
      s1_count_r  <= count_nxt;
    end
  end

  // Each product is Q9.23; the midscale offset is added in the same format
  // and the integer part is the floor of the total.
  always_comb begin
    prod_a = $signed({1'b0, amp_a_r}) * s1_sine_a_r;
    prod_b = $signed({1'b0, amp_b_r}) * s1_sine_b_r;
    total  = SUM_BITS'(prod_a) + SUM_BITS'(prod_b) + MID_OFFSET;
    if (total[SUM_BITS-1]) begin
      code = 8'd0;
      clip = 1'b1;
    end else if (|total[SUM_BITS-2:tts_pkg::FRAC_BITS+8]) begin
      code = 8'(tts_pkg::MAX_CODE);
      clip = 1'b1;
    end else begin
      code = total[tts_pkg::FRAC_BITS+7:tts_pkg::FRAC_BITS];
      clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_code_r  <= code;
      out_clip_r  <= clip;
      out_count_r <= s1_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_code_r};
  assign out_tuser  = out_clip_r;

endmodule

FILE: design/tts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_checker - port-level checks for the two-tone sine synthesizer
// Output hold under stall, clip flag consistency and reset behavior.
// ----------------------------------------------------------------------------
module tts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // A stalled output word keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // A clipped sample always sits at one of the rails.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[7:0] == 8'd0) || (out_tdata[7:0] == 8'(tts_pkg::MAX_CODE)))
    else $error("clip flag set on a code that is not a rail");

  // Reset empties the pipeline.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind two_tone_sine_synthesizer tts_checker u_tts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the two-tone sine synthesizer
// Streams restart flags into the block and compares every DAC word with a
// bit-exact software synthesizer. It moves through several register settings,
// including the extremes, and idles both stream sides at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_HALF    = 5;
  localparam int RESET_LEN   = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 4;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_WORDS = 155;
  localparam int RAND_PHASES = 6;

  // One expected output word of the synthesizer.
  typedef struct {
    logic [7:0]  code;
    logic        clip;
    logic [31:0] count;
  } dac_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a software copy of the synthesizer. It keeps its own registers,
  // phase accumulators and sample count, and queues the word each accepted
  // tick must produce.
  // --------------------------------------------------------------------------
  class dac_scoreboard;
    int          wave[tts_pkg::SINE_TABLE_ENTRIES];
    logic [15:0] amp[2];
    logic [31:0] step[2];
    logic [31:0] phase[2];
    logic [31:0] ticks;
    dac_word_t   expected_words[$];
    int          errors;

    function new();
      for (int k = 0; k < tts_pkg::SINE_TABLE_ENTRIES; k++) begin
        wave[k] = wave_value(k);
      end
      amp[0]   = 16'd10240;
      amp[1]   = 16'd20480;
      step[0]  = 32'd1288490;
      step[1]  = 32'd2147484;
      phase[0] = '0;
      phase[1] = '0;
      ticks    = '0;
      errors   = 0;
    endfunction

    // Table entry k: the angle is folded into the first quadrant as a Q30
    // turn fraction, turned into Q30 radians and run through the odd Taylor
    // terms up to x^15, then rounded into Q1.15.
    function int wave_value(int k);
      logic [63:0] turn;
      logic [63:0] frac;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] mag;
      logic [1:0]  quad;
      longint      acc;
      turn = ((64'(k) << 32) / tts_pkg::SINE_TABLE_ENTRIES) & 64'hFFFF_FFFF;
      quad = turn[31:30];
      frac = {34'd0, turn[29:0]};
      if (quad[0]) begin
        frac = tts_pkg::Q30_ONE - frac;
      end
      x    = (frac * tts_pkg::HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      mag = 64'(acc);
      if (mag > tts_pkg::Q30_ONE) begin
        mag = tts_pkg::Q30_ONE;
      end
      mag = (mag * 64'd32767 + (64'd1 << 29)) >> 30;
      if (quad[1]) begin
        return -int'(mag);
      end
      return int'(mag);
    endfunction

    // Amplitudes keep only their low 16 bits.
    function void set_reg(tts_pkg::cfg_reg_t idx, logic [31:0] val);
      case (idx)
        tts_pkg::REG_TONE_A_AMP:  amp[0]  = val[15:0];
        tts_pkg::REG_TONE_B_AMP:  amp[1]  = val[15:0];
        tts_pkg::REG_TONE_A_STEP: step[0] = val;
        tts_pkg::REG_TONE_B_STEP: step[1] = val;
        default: ;
      endcase
    endfunction

    // One sample tick: sum of the tones in Q9.23 around midscale, floored
    // and saturated, then the phases advance.
    function void note_tick(logic restart);
      longint    total;
      dac_word_t w;
      if (restart) begin
        phase[0] = '0;
        phase[1] = '0;
        ticks    = '0;
      end
      total = 0;
      for (int i = 0; i < tts_pkg::TONE_COUNT; i++) begin
        total = total + longint'({48'd0, amp[i]}) *
                longint'(wave[phase[i] >> (tts_pkg::PHASE_BITS - tts_pkg::IDX_BITS)]);
        phase[i] = phase[i] + step[i];
      end
      total = total + (longint'(tts_pkg::MID_CODE) <<< tts_pkg::FRAC_BITS);
      w.clip = 1'b0;
      if (total < 0) begin
        w.code = 8'd0;
        w.clip = 1'b1;
      end else if ((total >>> tts_pkg::FRAC_BITS) > tts_pkg::MAX_CODE) begin
        w.code = 8'd255;
        w.clip = 1'b1;
      end else begin
        w.code = total[tts_pkg::FRAC_BITS +: 8];
      end
      ticks   = ticks + 32'd1;
      w.count = ticks;
      expected_words.push_back(w);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) begin
        $display("ERROR at %0t: %s", $realtime, what);
      end
    endtask

    task check_word(logic [7:0] code, logic clip, logic [31:0] count);
      dac_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("output word with none expected (code %0d)", code));
        return;
      end
      w = expected_words.pop_front();
      if (code !== w.code) begin
        report($sformatf("sample %0d: dac_code %0d, expected %0d", w.count, code, w.code));
      end
      if (clip !== w.clip) begin
        report($sformatf("sample %0d: clipped %b, expected %b", w.count, clip, w.clip));
      end
      if (count !== w.count) begin
        report($sformatf("samples_made %0d, expected %0d", count, w.count));
      end
    endtask

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wen;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  dac_scoreboard sb;
  int            cycle_count;
  bit            quiet;       // no idling on either side in the last phase
  bit            hold_req;    // asks the receiver for one long hold-off
  int            stall_left;

  two_tone_sine_synthesizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [0] restart, [7:1] zero fill
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [7:0] dac_code, [39:8] samples_made
    .out_tuser  (out_tuser),    // [0] clipped
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("two_tone_sine_synthesizer: mismatch");
      $finish;
    end
  end

  // Receiver. Each edge first checks a word that was taken at that edge, then
  // decides out_tready for the next cycle. Short random stalls come in bursts;
  // a hold request turns into one long stall counted here, which lets the
  // pipeline fill so that in_tready has to drop.
  initial begin
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_word(out_tdata[7:0], out_tuser, out_tdata[39:8]);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offers one sample tick and waits for it to be taken. in_tvalid stays high
  // into the next word unless a random gap is inserted here.
  task automatic send_tick(input logic restart);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart};
    do begin
      @(posedge clk);
    end while (!in_tready);
    sb.note_tick(restart);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Stops the input, waits until every expected word is out and then lets the
  // block settle so that nothing is in flight when registers change.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input tts_pkg::cfg_reg_t idx, input logic [31:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Loads all four registers, then lowers the write enable.
  task automatic load_tones(input logic [31:0] amp_a, input logic [31:0] amp_b,
                            input logic [31:0] step_a, input logic [31:0] step_b);
    write_reg(tts_pkg::REG_TONE_A_AMP, amp_a);
    write_reg(tts_pkg::REG_TONE_B_AMP, amp_b);
    write_reg(tts_pkg::REG_TONE_A_STEP, step_a);
    write_reg(tts_pkg::REG_TONE_B_STEP, step_b);
    cfg_wen <= 1'b0;
  endtask

  // Random amplitude with the extremes and quiet tones well represented; the
  // upper half of the write data is junk that the block must drop.
  function automatic logic [31:0] pick_amp();
    logic [15:0] a;
    case ($urandom_range(0, 4))
      0:       a = 16'h0000;
      1:       a = 16'hFFFF;
      2:       a = 16'($urandom_range(0, 16'h4000));
      default: a = 16'($urandom);
    endcase
    return {16'($urandom), a};
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(1, 24'hFF_FFFF));
      3:       return 32'h4000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    sb          = new();
    quiet       = 1'b0;
    hold_req    = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_wen    <= 1'b0;
    cfg_index  <= tts_pkg::REG_TONE_A_AMP;
    cfg_wdata  <= '0;
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: a plain run broken by a restart.
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // Full-scale tones on quarter-turn steps walk through zero, the positive
    // peak and the negative peak, so the code clips high and low. The amplitude
    // writes carry junk in their upper half.
    load_tones(32'hABCD_FFFF, 32'h1234_FFFF, 32'h4000_0000, 32'h4000_0000);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // A half-count tone stepping backwards by the smallest amount checks that
    // tiny negative sums floor down to 127; the silent second tone holds still.
    load_tones(32'h0000_0080, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // Random phases, each with fresh register values. The second one asks for
    // a long receiver hold-off while words keep coming; the last one runs
    // without any idling.
    for (int p = 0; p < RAND_PHASES; p++) begin
      load_tones(pick_amp(), pick_amp(), pick_step(), pick_step());
      if (p == RAND_PHASES - 1) begin
        quiet = 1'b1;
      end
      if (p == 1) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_tick($urandom_range(0, 31) == 0);
      end
      drain();
    end

    if (sb.pending() > 0) begin
      sb.report($sformatf("%0d expected words never came out", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("two_tone_sine_synthesizer: match");
    end else begin
      $display("two_tone_sine_synthesizer: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/tts_pkg.sv
design/two_tone_sine_synthesizer.sv
design/tts_checker.sv
bench/tb.sv
